FILE: sv/bot_pkg.sv
// Shared widths, types and constants for the box overlap test pipeline.
package bot_pkg;

   // Coordinate width of every box edge
   localparam int COORD_BITS  = 16;
   // Edge difference or edge sum, one bit wider than a coordinate
   localparam int DIFF_BITS   = COORD_BITS + 1;
   // Clamped overlap extent, never negative, at most 2^COORD_BITS - 1
   localparam int SPAN_BITS   = COORD_BITS;
   // Signed box area
   localparam int AREA_BITS   = 2 * DIFF_BITS;
   // Sum of both areas
   localparam int ASUM_BITS   = AREA_BITS + 1;
   // Union, area sum minus intersection
   localparam int UNI_BITS    = ASUM_BITS + 1;
   // Intersection area, unsigned
   localparam int INTER_BITS  = 2 * SPAN_BITS;

   // Threshold in Q1.16
   localparam int THRESH_BITS = 17;
   localparam int Q16_SHIFT   = 16;
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 17'd32768;

   // Width of the final cross-multiplied compare
   localparam int CMP_BITS    = (UNI_BITS - 1) + THRESH_BITS;

   // Stream payload widths
   localparam int REQ_DATA_BITS = ((8 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = 8;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [AREA_BITS-1:0]  area_type;

   typedef struct packed {
      coord_type left;
      coord_type top;
      coord_type right;
      coord_type bottom;
   } box_type;

   // Geometry results handed to the area stages
   typedef struct packed {
      logic                  center_hit;
      logic [SPAN_BITS-1:0]  iw;
      logic [SPAN_BITS-1:0]  ih;
      area_type              area_a;
      area_type              area_b;
   } geom_type;

   // Intersection and union handed to the ratio stages
   typedef struct packed {
      logic                  center_hit;
      logic                  inter_pos;
      logic                  uni_pos;
      logic [INTER_BITS-1:0] inter;
      logic [UNI_BITS-1:0]   uni;
   } isect_type;

endpackage

FILE: sv/bot_geom.sv
// Stages one and two: centers, edge min/max, extents, containment and box areas.
module bot_geom (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  bot_pkg::box_type   in_a,
   input  bot_pkg::box_type   in_b,
   output logic               out_valid,
   input  logic               out_ready,
   output bot_pkg::geom_type  out_geom
);

   typedef struct packed {
      bot_pkg::box_type    a;
      bot_pkg::box_type    b;
      bot_pkg::coord_type  acx;
      bot_pkg::coord_type  acy;
      bot_pkg::coord_type  bcx;
      bot_pkg::coord_type  bcy;
      bot_pkg::coord_type  l;
      bot_pkg::coord_type  t;
      bot_pkg::coord_type  r;
      bot_pkg::coord_type  btm;
      bot_pkg::diff_type   aw;
      bot_pkg::diff_type   ah;
      bot_pkg::diff_type   bw;
      bot_pkg::diff_type   bh;
   } edge_type;

   logic                v1_ff, v1_in;
   edge_type            s1_ff, s1_in;
   logic                v2_ff, v2_in;
   bot_pkg::geom_type   s2_ff, s2_in;
   logic                adv1, adv2;

   bot_pkg::diff_type   sum_acx, sum_acy, sum_bcx, sum_bcy;
   bot_pkg::diff_type   dx, dy;
   logic                a_has_b, b_has_a;

   // Stall handling: a stage loads when empty or when its successor moves
   assign adv2     = !v2_ff || out_ready;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   // Stage one: floored centers, overlap edges, box extents
   always_comb begin
      sum_acx = bot_pkg::DIFF_BITS'(in_a.left) + bot_pkg::DIFF_BITS'(in_a.right);
      sum_acy = bot_pkg::DIFF_BITS'(in_a.top)  + bot_pkg::DIFF_BITS'(in_a.bottom);
      sum_bcx = bot_pkg::DIFF_BITS'(in_b.left) + bot_pkg::DIFF_BITS'(in_b.right);
      sum_bcy = bot_pkg::DIFF_BITS'(in_b.top)  + bot_pkg::DIFF_BITS'(in_b.bottom);
      s1_in.a   = in_a;
      s1_in.b   = in_b;
      // dropping the low bit of a two's complement sum floors the half
      s1_in.acx = sum_acx[bot_pkg::DIFF_BITS-1:1];
      s1_in.acy = sum_acy[bot_pkg::DIFF_BITS-1:1];
      s1_in.bcx = sum_bcx[bot_pkg::DIFF_BITS-1:1];
      s1_in.bcy = sum_bcy[bot_pkg::DIFF_BITS-1:1];
      s1_in.l   = (in_a.left   > in_b.left)   ? in_a.left   : in_b.left;
      s1_in.t   = (in_a.top    > in_b.top)    ? in_a.top    : in_b.top;
      s1_in.r   = (in_a.right  < in_b.right)  ? in_a.right  : in_b.right;
      s1_in.btm = (in_a.bottom < in_b.bottom) ? in_a.bottom : in_b.bottom;
      s1_in.aw  = bot_pkg::DIFF_BITS'(in_a.right)  - bot_pkg::DIFF_BITS'(in_a.left);
      s1_in.ah  = bot_pkg::DIFF_BITS'(in_a.bottom) - bot_pkg::DIFF_BITS'(in_a.top);
      s1_in.bw  = bot_pkg::DIFF_BITS'(in_b.right)  - bot_pkg::DIFF_BITS'(in_b.left);
      s1_in.bh  = bot_pkg::DIFF_BITS'(in_b.bottom) - bot_pkg::DIFF_BITS'(in_b.top);
      v1_in     = in_valid;
   end

   // Stage two: containment with edges included, clamped extents, areas
   always_comb begin
      a_has_b = (s1_ff.a.left <= s1_ff.bcx) && (s1_ff.bcx <= s1_ff.a.right) &&
                (s1_ff.a.top  <= s1_ff.bcy) && (s1_ff.bcy <= s1_ff.a.bottom);
      b_has_a = (s1_ff.b.left <= s1_ff.acx) && (s1_ff.acx <= s1_ff.b.right) &&
                (s1_ff.b.top  <= s1_ff.acy) && (s1_ff.acy <= s1_ff.b.bottom);
      dx = bot_pkg::DIFF_BITS'(s1_ff.r)   - bot_pkg::DIFF_BITS'(s1_ff.l);
      dy = bot_pkg::DIFF_BITS'(s1_ff.btm) - bot_pkg::DIFF_BITS'(s1_ff.t);
      s2_in.center_hit = a_has_b || b_has_a;
      s2_in.iw = (dx > 0) ? dx[bot_pkg::SPAN_BITS-1:0] : '0;
      s2_in.ih = (dy > 0) ? dy[bot_pkg::SPAN_BITS-1:0] : '0;
      s2_in.area_a = bot_pkg::AREA_BITS'(s1_ff.aw) * bot_pkg::AREA_BITS'(s1_ff.ah);
      s2_in.area_b = bot_pkg::AREA_BITS'(s1_ff.bw) * bot_pkg::AREA_BITS'(s1_ff.bh);
      v2_in = v1_ff;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= v1_in;
         if (adv2) v2_ff <= v2_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (adv1) s1_ff <= s1_in;
      if (adv2) s2_ff <= s2_in;
   end

   assign out_valid = v2_ff;
   assign out_geom  = s2_ff;

endmodule

FILE: sv/bot_area.sv
// Stages three and four: intersection area, area sum and union.
module bot_area (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  bot_pkg::geom_type   in_geom,
   output logic                out_valid,
   input  logic                out_ready,
   output bot_pkg::isect_type  out_isect
);

   typedef struct packed {
      logic                           center_hit;
      logic                           inter_pos;
      logic [bot_pkg::INTER_BITS-1:0] inter;
      logic signed [bot_pkg::ASUM_BITS-1:0] asum;
   } prod_type;

   logic                 v3_ff, v3_in;
   prod_type             s3_ff, s3_in;
   logic                 v4_ff, v4_in;
   bot_pkg::isect_type   s4_ff, s4_in;
   logic                 adv3, adv4;
   logic [bot_pkg::UNI_BITS-1:0] uni;

   assign adv4     = !v4_ff || out_ready;
   assign adv3     = !v3_ff || adv4;
   assign in_ready = adv3;

   // Stage three: intersection product and sum of both areas
   always_comb begin
      s3_in.center_hit = in_geom.center_hit;
      s3_in.inter_pos  = (in_geom.iw != '0) && (in_geom.ih != '0);
      s3_in.inter = bot_pkg::INTER_BITS'(in_geom.iw) * bot_pkg::INTER_BITS'(in_geom.ih);
      s3_in.asum  = bot_pkg::ASUM_BITS'(in_geom.area_a) +
                    bot_pkg::ASUM_BITS'(in_geom.area_b);
      v3_in = in_valid;
   end

   // Stage four: union and its sign
   always_comb begin
      uni = bot_pkg::UNI_BITS'(s3_ff.asum) - bot_pkg::UNI_BITS'(s3_ff.inter);
      s4_in.center_hit = s3_ff.center_hit;
      s4_in.inter_pos  = s3_ff.inter_pos;
      s4_in.uni_pos    = !uni[bot_pkg::UNI_BITS-1] && (uni != '0);
      s4_in.inter      = s3_ff.inter;
      s4_in.uni        = uni;
      v4_in = v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv3) v3_ff <= v3_in;
         if (adv4) v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) s3_ff <= s3_in;
      if (adv4) s4_ff <= s4_in;
   end

   assign out_valid = v4_ff;
   assign out_isect = s4_ff;

endmodule

FILE: sv/bot_ratio.sv
// Stages five and six: threshold product and the final IoU decision.
module bot_ratio (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [bot_pkg::THRESH_BITS-1:0]   threshold,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  bot_pkg::isect_type                in_isect,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic                              out_overlaps,
   output logic                              out_by_center
);

   typedef struct packed {
      logic                         center_hit;
      logic                         thr_zero;
      logic                         both_pos;
      logic [bot_pkg::CMP_BITS-1:0] lhs;
      logic [bot_pkg::CMP_BITS-1:0] rhs;
   } cmp_type;

   typedef struct packed {
      logic overlaps;
      logic by_center;
   } verdict_type;

   logic          v5_ff, v5_in;
   cmp_type       s5_ff, s5_in;
   logic          v6_ff, v6_in;
   verdict_type   s6_ff, s6_in;
   logic          adv5, adv6;

   assign adv6     = !v6_ff || out_ready;
   assign adv5     = !v5_ff || adv6;
   assign in_ready = adv5;

   // Stage five: intersection scaled by one in Q1.16, union times threshold
   always_comb begin
      s5_in.center_hit = in_isect.center_hit;
      s5_in.thr_zero   = (threshold == '0);
      s5_in.both_pos   = in_isect.inter_pos && in_isect.uni_pos;
      s5_in.lhs = bot_pkg::CMP_BITS'({in_isect.inter, {bot_pkg::Q16_SHIFT{1'b0}}});
      // union is known positive whenever the product is used
      s5_in.rhs = bot_pkg::CMP_BITS'(in_isect.uni[bot_pkg::UNI_BITS-2:0]) *
                  bot_pkg::CMP_BITS'(threshold);
      v5_in = in_valid;
   end

   // Stage six: center containment or a zero threshold wins, else the exact ratio compare
   always_comb begin
      s6_in.by_center = s5_ff.center_hit;
      s6_in.overlaps  = s5_ff.center_hit || s5_ff.thr_zero ||
                        (s5_ff.both_pos && (s5_ff.lhs >= s5_ff.rhs));
      v6_in = v5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (adv5) v5_ff <= v5_in;
         if (adv6) v6_ff <= v6_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv5) s5_ff <= s5_in;
      if (adv6) s6_ff <= s6_in;
   end

   assign out_valid     = v6_ff;
   assign out_overlaps  = s6_ff.overlaps;
   assign out_by_center = s6_ff.by_center;

endmodule

FILE: sv/box_overlap_test.sv
// Top level of the box overlap test: stream ports, threshold register, pipeline.
//
// Takes one pair of boxes per clock and returns one verdict per pair while rsp_tready
// does not stall the pipe; rsp_tvalid rises once the pair has passed six register
// stages, the first loading on the accepting edge. Throughput is one transaction per
// cycle without back-pressure, set by the six-stage pipeline (the widest step is the
// union-times-threshold product in stage five). Each stage holds a valid bit and
// loads whenever it is empty or its successor moves, so a stalled result still lets
// new pairs fill empty stages.
// A pair overlaps when either box contains the other's floored center, edges
// included (rsp_tuser is then 1), or else when intersection * 65536 >=
// threshold * union with intersection and union both positive; a zero threshold
// always passes.
// Write the Q1.16 threshold (reset 32768) only while no transaction is in flight.
module box_overlap_test (
   input  logic                                clock,
   input  logic                                reset,
   // csr: overlap threshold, Q1.16
   input  logic                                csr_wen,
   input  logic [bot_pkg::THRESH_BITS-1:0]     csr_wdata,
   // req_tdata, low bits up: first_left, first_top, first_right, first_bottom,
   //   second_left, second_top, second_right, second_bottom
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bot_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // rsp_tdata, low bits up: overlaps, zero fill
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bot_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // rsp_tuser: by_center
   output logic                                rsp_tuser
);

   localparam int C = bot_pkg::COORD_BITS;

   logic [bot_pkg::THRESH_BITS-1:0] thresh_ff, thresh_in;
   bot_pkg::box_type    box_a, box_b;
   logic                geom_valid, geom_ready;
   bot_pkg::geom_type   geom;
   logic                isect_valid, isect_ready;
   bot_pkg::isect_type  isect;
   logic                overlaps;

   // Threshold register
   assign thresh_in = csr_wen ? csr_wdata : thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= bot_pkg::THRESH_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   // Unpack the request fields
   assign box_a.left   = req_tdata[0*C +: C];
   assign box_a.top    = req_tdata[1*C +: C];
   assign box_a.right  = req_tdata[2*C +: C];
   assign box_a.bottom = req_tdata[3*C +: C];
   assign box_b.left   = req_tdata[4*C +: C];
   assign box_b.top    = req_tdata[5*C +: C];
   assign box_b.right  = req_tdata[6*C +: C];
   assign box_b.bottom = req_tdata[7*C +: C];

   bot_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_a      (box_a),
      .in_b      (box_b),
      .out_valid (geom_valid),
      .out_ready (geom_ready),
      .out_geom  (geom)
   );

   bot_area u_area (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (geom_valid),
      .in_ready  (geom_ready),
      .in_geom   (geom),
      .out_valid (isect_valid),
      .out_ready (isect_ready),
      .out_isect (isect)
   );

   bot_ratio u_ratio (
      .clock         (clock),
      .reset         (reset),
      .threshold     (thresh_ff),
      .in_valid      (isect_valid),
      .in_ready      (isect_ready),
      .in_isect      (isect),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_overlaps  (overlaps),
      .out_by_center (rsp_tuser)
   );

   assign rsp_tdata = bot_pkg::RSP_DATA_BITS'(overlaps);

endmodule

FILE: tb/sv/box_overlap_test_test.sv
// Self-checking testbench for box_overlap_test: predicts each overlap verdict and compares.
module box_overlap_test_test;

   localparam int CYCLE_LIMIT = 200000;
   // Pipeline depth plus margin, used before threshold writes and at the end
   localparam int SETTLE_CYCLES = 12;

   typedef struct {
      bot_pkg::box_type first;
      bot_pkg::box_type second;
   } box_pair_type;

   typedef struct {
      logic overlaps;
      logic by_center;
   } verdict_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_wen = 1'b0;
   logic [bot_pkg::THRESH_BITS-1:0]     csr_wdata = '0;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   // req_tdata, low bits up: first_left, first_top, first_right, first_bottom,
   //   second_left, second_top, second_right, second_bottom
   logic [bot_pkg::REQ_DATA_BITS-1:0]   req_tdata = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b1;
   // rsp_tdata, low bits up: overlaps, zero fill
   logic [bot_pkg::RSP_DATA_BITS-1:0]   rsp_tdata;
   // rsp_tuser: by_center
   logic                                rsp_tuser;

   // Predictor copy of the threshold register
   logic [bot_pkg::THRESH_BITS-1:0]     threshold_q16 = bot_pkg::THRESH_RESET;
   verdict_type                         verdict_queue[$];
   int unsigned                         mismatch_count = 0;
   int unsigned                         cycle_count = 0;
   int unsigned                         send_idle_pct = 0;
   int unsigned                         recv_stall_pct = 0;

   box_overlap_test dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Result checker: every accepted transaction against the oldest expected verdict
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: overlaps=%0b by_center=%0b",
                        rsp_tdata[0], rsp_tuser);
         end else begin
            want = verdict_queue.pop_front();
            if (rsp_tdata[0] !== want.overlaps || rsp_tuser !== want.by_center) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected overlaps=%0b by_center=%0b, got %0b %0b",
                           want.overlaps, want.by_center, rsp_tdata[0], rsp_tuser);
            end
         end
      end
   end

   function automatic bot_pkg::coord_type clip(int v);
      if (v > 32767) return bot_pkg::coord_type'(32767);
      if (v < -32768) return bot_pkg::coord_type'(-32768);
      return bot_pkg::coord_type'(v);
   endfunction

   function automatic bot_pkg::box_type make_box(int l, int t, int r, int b);
      bot_pkg::box_type bx;
      bx.left = clip(l);
      bx.top = clip(t);
      bx.right = clip(r);
      bx.bottom = clip(b);
      return bx;
   endfunction

   function automatic bit holds(longint l, longint t, longint r, longint b,
                                longint x, longint y);
      return l <= x && x <= r && t <= y && y <= b;
   endfunction

   // Overlap verdict: center containment first, else exact cross-multiplied IoU test
   function automatic verdict_type judge_pair(box_pair_type p);
      longint fl, ft, fr, fb, sl, st, sr, sb;
      longint fcx, fcy, scx, scy, w, h, inter, uni;
      verdict_type v;
      fl = p.first.left;   ft = p.first.top;
      fr = p.first.right;  fb = p.first.bottom;
      sl = p.second.left;  st = p.second.top;
      sr = p.second.right; sb = p.second.bottom;
      // arithmetic shift floors odd negative sums
      fcx = (fl + fr) >>> 1;  fcy = (ft + fb) >>> 1;
      scx = (sl + sr) >>> 1;  scy = (st + sb) >>> 1;
      if (holds(fl, ft, fr, fb, scx, scy) || holds(sl, st, sr, sb, fcx, fcy)) begin
         v.overlaps = 1'b1;
         v.by_center = 1'b1;
         return v;
      end
      v.by_center = 1'b0;
      w = ((fr < sr) ? fr : sr) - ((fl > sl) ? fl : sl);
      h = ((fb < sb) ? fb : sb) - ((ft > st) ? ft : st);
      if (w < 0) w = 0;
      if (h < 0) h = 0;
      inter = w * h;
      if (inter <= 0) begin
         v.overlaps = (threshold_q16 == 0);
      end else begin
         uni = (fr - fl) * (fb - ft) + (sr - sl) * (sb - st) - inter;
         if (uni <= 0)
            v.overlaps = (threshold_q16 == 0);
         else
            v.overlaps = (inter * 65536 >= longint'(threshold_q16) * uni);
      end
      return v;
   endfunction

   // Send one pair; returns at the falling edge after it is accepted
   task automatic send_pair(input box_pair_type p);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {p.second.bottom, p.second.right, p.second.top, p.second.left,
                    p.first.bottom, p.first.right, p.first.top, p.first.left};
      do @(posedge clock); while (!req_tready);
      verdict_queue.insert(verdict_queue.size(), judge_pair(p));
      @(negedge clock);
   endtask

   task automatic send_boxes(input bot_pkg::box_type a, input bot_pkg::box_type b);
      box_pair_type p;
      p.first = a;
      p.second = b;
      send_pair(p);
   endtask

   // Hold off the sender until every outstanding verdict has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (verdict_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [bot_pkg::THRESH_BITS-1:0] value);
      wait_drained();
      csr_wen <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      threshold_q16 = value;
   endtask

   // Random pair: mostly nearby boxes with random sizes, some raw noise, some inverted
   function automatic box_pair_type random_pair();
      box_pair_type p;
      int kind, span, ax, ay, bx, by;
      kind = $urandom_range(99);
      if (kind < 20) begin
         p.first = {$urandom, $urandom};
         p.second = {$urandom, $urandom};
         return p;
      end
      span = 1 << $urandom_range(1, 14);
      ax = int'($urandom_range(0, 65535)) - 32768;
      ay = int'($urandom_range(0, 65535)) - 32768;
      bx = ax + int'($urandom_range(0, 2 * span)) - span;
      by = ay + int'($urandom_range(0, 2 * span)) - span;
      p.first = make_box(ax, ay, ax + int'($urandom_range(0, span)),
                         ay + int'($urandom_range(0, span)));
      p.second = make_box(bx, by, bx + int'($urandom_range(0, span)),
                          by + int'($urandom_range(0, span)));
      if (kind >= 85) begin
         if ($urandom_range(1))
            {p.first.left, p.first.right} = {p.first.right, p.first.left};
         else
            {p.second.top, p.second.bottom} = {p.second.bottom, p.second.top};
      end
      return p;
   endfunction

   // Reset value of the threshold, edge cases of geometry
   task automatic test_directed();
      // identical boxes
      send_boxes(make_box(0, 0, 10, 10), make_box(0, 0, 10, 10));
      // corners touch: empty intersection
      send_boxes(make_box(0, 0, 10, 10), make_box(10, 10, 20, 20));
      // center sits exactly on the other box's edge
      send_boxes(make_box(0, 0, 10, 10), make_box(5, 5, 15, 15));
      // odd negative sum: floored center falls just outside
      send_boxes(make_box(-3, -3, 0, 0), make_box(-1, -1, 5, 5));
      // far apart at the coordinate extremes
      send_boxes(make_box(-32768, -32768, -32000, -32000),
                 make_box(32000, 32000, 32767, 32767));
      // full-range boxes
      send_boxes(make_box(-32768, -32768, 32767, 32767),
                 make_box(-32768, -32768, 32767, 32767));
      send_boxes(make_box(-32768, -32768, 32767, 32767),
                 make_box(32766, 32766, 32767, 32767));
      // inverted boxes
      send_boxes(make_box(10, 10, 0, 0), make_box(0, 0, 10, 10));
      send_boxes(make_box(10, 10, 0, 0), make_box(20, 20, 5, 5));
      send_boxes(make_box(32767, 32767, -32768, -32768), make_box(-1, -1, -1, -1));
      // zero-area boxes
      send_boxes(make_box(0, 0, 0, 0), make_box(0, 0, 0, 0));
      send_boxes(make_box(0, 0, 0, 10), make_box(1, 0, 1, 10));
      // partial overlap without center containment, IoU exactly 1/4
      send_boxes(make_box(0, 0, 10, 100), make_box(6, 0, 16, 100));
   endtask

   // Threshold sweep around the exact-equality point and the extremes
   task automatic test_thresholds();
      logic [bot_pkg::THRESH_BITS-1:0] sweep[5];
      sweep = '{17'd0, 17'd16384, 17'd16385, 17'd65536, 17'h1FFFF};
      foreach (sweep[i]) begin
         write_threshold(sweep[i]);
         send_boxes(make_box(0, 0, 10, 100), make_box(6, 0, 16, 100));
         send_boxes(make_box(0, 0, 10, 10), make_box(10, 0, 20, 10));
         send_boxes(make_box(-20, -20, -10, -10), make_box(-14, -14, -4, -4));
      end
   endtask

   // Random pairs under one idling pattern and two thresholds
   task automatic test_random(input int unsigned send_pct, input int unsigned recv_pct,
                              input int n,
                              input logic [bot_pkg::THRESH_BITS-1:0] thr_a,
                              input logic [bot_pkg::THRESH_BITS-1:0] thr_b);
      write_threshold(thr_a);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      repeat (n / 2) send_pair(random_pair());
      write_threshold(thr_b);
      repeat (n - n / 2) send_pair(random_pair());
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_thresholds();
      test_random(27, 57, 134, 17'($urandom_range(1, 20000)), 17'd0);
      test_random(57, 27, 134, 17'($urandom_range(0, 65536)), 17'd65536);
      test_random(0, 0, 134, 17'($urandom_range(65537, 131071)),
                  17'($urandom_range(4000, 16000)));

      wait_drained();
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: box_overlap_test.f
sv/bot_pkg.sv
sv/bot_geom.sv
sv/bot_area.sv
sv/bot_ratio.sv
sv/box_overlap_test.sv
tb/sv/box_overlap_test_test.sv
